// ===== hw/rtl/plcm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcm_pkg
// Shared types and constants for the per-ID call latency monitor.
// ---------------------------------------------------------------------------
package plcm_pkg;

  // Table geometry: one entry for every possible call identifier.
  localparam int ID_W        = 6;
  localparam int ENTRY_COUNT = 2 ** ID_W;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_START_BUSY  = 2'd1,
    STAT_END_IDLE    = 2'd2,
    STAT_END_UNKNOWN = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_UPDATE
  } state_t;

  // One row of the statistics table.
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  total;
    logic [TIME_W-1:0]  min_t;
    logic [TIME_W-1:0]  max_t;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read;
    logic diff;
    logic update;
  } dp_cmd_t;

endpackage : plcm_pkg
`default_nettype wire

// ===== hw/rtl/per_id_call_latency_monitor_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// per_id_call_latency_monitor_unit
// Per-ID call latency monitor: records call start times per identifier and
// keeps count, total, minimum and maximum elapsed time for each.
// ---------------------------------------------------------------------------
// Each transaction is one command (call start, call end, frame tick or none) with a
// call id and a 64-bit nanosecond timestamp, and yields one result holding the
// status and the id's statistics after the command. The entry table is a
// memory that is read and then written back, so a transaction passes
// through four steps (accept, table read, elapsed-time subtract, update); a
// new transaction is taken only once the last has passed the update step.
// The result sits in an output register, so the next transaction is
// accepted while a result still waits; a result that is not taken holds the
// update step. No transaction is taken during reset.
// Entries are marked valid by flip-flops cleared at reset; no clearing pass.
// ---------------------------------------------------------------------------
module per_id_call_latency_monitor_unit
  import plcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [ID_W-1:0]    call_id,
  input  wire logic [TIME_W-1:0]  timestamp_ns,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [STAT_W-1:0]  status,
  output logic      [COUNT_W-1:0] call_count,
  output logic      [TIME_W-1:0]  total_time,
  output logic      [TIME_W-1:0]  min_time,
  output logic      [TIME_W-1:0]  max_time,
  output logic      [COUNT_W-1:0] frames_seen,
  output logic      [TIME_W-1:0]  all_calls_time
);

  dp_cmd_t dp_cmd;

  // Sequencer.
  plcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  // Table and arithmetic.
  plcm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .command        (command),
    .call_id        (call_id),
    .timestamp_ns   (timestamp_ns),
    .status         (status),
    .call_count     (call_count),
    .total_time     (total_time),
    .min_time       (min_time),
    .max_time       (max_time),
    .frames_seen    (frames_seen),
    .all_calls_time (all_calls_time)
  );

  // Once a transaction is taken, no other is taken until it has been worked.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another is in progress");

  // An end on an unknown id reports empty statistics.
  a_unknown_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_END_UNKNOWN) |->
      (call_count == '0 && total_time == '0 && max_time == '0))
    else $error("unknown-id result carries statistics");

  // An entry with completed calls never has its minimum above its maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && call_count != '0) |-> (min_time <= max_time))
    else $error("minimum exceeds maximum");

endmodule : per_id_call_latency_monitor_unit
`default_nettype wire

// ===== hw/rtl/plcm_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcm_ctrl
// Sequencer for the monitor: steps each transaction through table read,
// elapsed-time calculation and update, and owns the output valid flag.
// ---------------------------------------------------------------------------
module plcm_ctrl
  import plcm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      dp_cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ:   state_next = S_DIFF;
      S_DIFF:   state_next = S_UPDATE;
      S_UPDATE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Output logic. Nothing is taken while reset is held.
  always_comb begin
    in_ready = 1'b0;
    dp_cmd   = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = !rst;
        dp_cmd.load = in_valid && !rst;
      end
      S_READ:   dp_cmd.read   = 1'b1;
      S_DIFF:   dp_cmd.diff   = 1'b1;
      S_UPDATE: dp_cmd.update = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule : plcm_ctrl
`default_nettype wire

// ===== hw/rtl/plcm_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// plcm_datapath
// Statistics table, global counters and the result register. Performs the
// read-modify-write of one table entry under control of the sequencer.
// ---------------------------------------------------------------------------
module plcm_datapath
  import plcm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            dp_cmd,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [ID_W-1:0]    call_id,
  input  wire logic [TIME_W-1:0]  timestamp_ns,
  output logic      [STAT_W-1:0]  status,
  output logic      [COUNT_W-1:0] call_count,
  output logic      [TIME_W-1:0]  total_time,
  output logic      [TIME_W-1:0]  min_time,
  output logic      [TIME_W-1:0]  max_time,
  output logic      [COUNT_W-1:0] frames_seen,
  output logic      [TIME_W-1:0]  all_calls_time
);

  // Captured transaction.
  cmd_t              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] ts_q;

  // Table, its valid bits and the registered read data.
  entry_t                 mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] entry_valid;
  entry_t                 rd_data;
  logic [TIME_W-1:0]      diff;

  // Global state.
  logic               busy;
  logic               busy_next;
  logic [COUNT_W-1:0] frame_total;
  logic [COUNT_W-1:0] frame_total_next;
  logic [TIME_W-1:0]  grand_total;
  logic [TIME_W-1:0]  grand_total_next;

  // Update results.
  logic    id_ok;
  logic    entry_hit;
  logic    wr_en;
  entry_t  wr_entry;
  entry_t  res_entry;
  logic    res_hit;
  status_t res_status;

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q <= cmd_t'(command);
      id_q  <= call_id;
      ts_q  <= timestamp_ns;
    end
  end

  // Table storage: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (dp_cmd.read) begin
      rd_data <= mem[id_q];
    end
    if (dp_cmd.update && wr_en) begin
      mem[id_q] <= wr_entry;
    end
  end

  // Elapsed time since the recorded start, modulo 2^64.
  always_ff @(posedge clk) begin
    if (dp_cmd.diff) begin
      diff <= ts_q - rd_data.stamp;
    end
  end

  assign id_ok     = 32'(id_q) < ENTRY_COUNT;
  assign entry_hit = id_ok && entry_valid[id_q];

  // Apply the command to the entry and the global counters.
  always_comb begin
    wr_entry         = rd_data;
    wr_en            = 1'b0;
    res_status       = STAT_OK;
    busy_next        = busy;
    frame_total_next = frame_total;
    grand_total_next = grand_total;
    res_entry        = rd_data;
    res_hit          = entry_hit;
    case (cmd_q)
      CMD_START: begin
        if (busy) res_status = STAT_START_BUSY;
        if (!entry_hit) begin
          wr_entry.count = '0;
          wr_entry.total = '0;
          wr_entry.min_t = '1;
          wr_entry.max_t = '0;
        end
        wr_entry.stamp = ts_q;
        wr_en          = id_ok;
        res_entry      = wr_entry;
        res_hit        = id_ok;
        busy_next      = 1'b1;
      end
      CMD_END: begin
        if (!entry_hit) begin
          res_status = STAT_END_UNKNOWN;
        end else begin
          if (!busy) res_status = STAT_END_IDLE;
          wr_entry.count   = rd_data.count + COUNT_W'(1);
          wr_entry.total   = rd_data.total + diff;
          if (rd_data.min_t > diff) wr_entry.min_t = diff;
          if (rd_data.max_t < diff) wr_entry.max_t = diff;
          wr_en            = 1'b1;
          res_entry        = wr_entry;
          grand_total_next = grand_total + diff;
          busy_next        = 1'b0;
        end
      end
      CMD_FRAME: begin
        frame_total_next = frame_total + COUNT_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Control and global state.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      busy        <= 1'b0;
      frame_total <= '0;
      grand_total <= '0;
    end else if (dp_cmd.update) begin
      if (wr_en) entry_valid[id_q] <= 1'b1;
      busy        <= busy_next;
      frame_total <= frame_total_next;
      grand_total <= grand_total_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (dp_cmd.update) begin
      status         <= res_status;
      call_count     <= res_hit ? res_entry.count : '0;
      total_time     <= res_hit ? res_entry.total : '0;
      min_time       <= res_hit ? res_entry.min_t : '0;
      max_time       <= res_hit ? res_entry.max_t : '0;
      frames_seen    <= frame_total_next;
      all_calls_time <= grand_total_next;
    end
  end

endmodule : plcm_datapath
`default_nettype wire

// ===== sim/per_id_call_latency_monitor_unit_test.sv =====
// ---------------------------------------------------------------------------
// per_id_call_latency_monitor_unit_test
// Self-checking bench for the per-ID call latency monitor. A directed set of
// commands covers the corner cases. A long random run, mostly made of matched
// start/end pairs, follows it. Every accepted command is applied to a local
// copy of the statistics table, and each returned result is compared field by
// field with the oldest predicted one. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module per_id_call_latency_monitor_unit_test
  import plcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  // One command transaction as presented to the block.
  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } call_cmd_t;

  // One statistics result as returned by the block.
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  total;
    logic [TIME_W-1:0]  min_t;
    logic [TIME_W-1:0]  max_t;
    logic [COUNT_W-1:0] frames;
    logic [TIME_W-1:0]  grand;
  } call_stats_t;

  logic clk;
  logic rst = 1'b1;

  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   command      = '0;
  logic [ID_W-1:0]    call_id      = '0;
  logic [TIME_W-1:0]  timestamp_ns = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] call_count;
  logic [TIME_W-1:0]  total_time;
  logic [TIME_W-1:0]  min_time;
  logic [TIME_W-1:0]  max_time;
  logic [COUNT_W-1:0] frames_seen;
  logic [TIME_W-1:0]  all_calls_time;

  per_id_call_latency_monitor_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .call_id        (call_id),
    .timestamp_ns   (timestamp_ns),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .call_count     (call_count),
    .total_time     (total_time),
    .min_time       (min_time),
    .max_time       (max_time),
    .frames_seen    (frames_seen),
    .all_calls_time (all_calls_time)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Commands waiting to be sent and statistics waiting to come back.
  call_cmd_t   pending_cmds[$];
  call_stats_t expected_stats[$];
  call_cmd_t   cmd_on_bus;

  int accepted_cmds = 0;
  int total_cmds    = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  // Idle bookkeeping for both sides.
  int send_gap   = 0;
  int send_calm  = 0;
  int recv_stall = 0;
  int recv_calm  = 0;
  int stall_len  = 0;

  // Shadow copy of the monitor's state.
  logic                call_busy = 1'b0;
  logic                entry_live[ENTRY_COUNT];
  logic [TIME_W-1:0]   started_at[ENTRY_COUNT];
  logic [COUNT_W-1:0]  calls_done[ENTRY_COUNT];
  logic [TIME_W-1:0]   time_sum[ENTRY_COUNT];
  logic [TIME_W-1:0]   time_min[ENTRY_COUNT];
  logic [TIME_W-1:0]   time_max[ENTRY_COUNT];
  logic [COUNT_W-1:0]  frame_ticks = '0;
  logic [TIME_W-1:0]   elapsed_sum = '0;

  initial begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      entry_live[i] = 1'b0;
    end
  end

  // Applies one command to the shadow table and returns the statistics the
  // block should report for it.
  function automatic call_stats_t apply_call_cmd(call_cmd_t c);
    call_stats_t       r;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    r.status = STAT_OK;
    case (c.cmd)
      CMD_START: begin
        if (call_busy) begin
          r.status = STAT_START_BUSY;
        end
        if (!entry_live[c.id]) begin
          entry_live[c.id] = 1'b1;
          calls_done[c.id] = '0;
          time_sum[c.id]   = '0;
          time_min[c.id]   = '1;
          time_max[c.id]   = '0;
        end
        started_at[c.id] = c.stamp;
        call_busy = 1'b1;
      end
      CMD_END: begin
        if (!entry_live[c.id]) begin
          r.status = STAT_END_UNKNOWN;
        end else begin
          if (!call_busy) begin
            r.status = STAT_END_IDLE;
          end
          elapsed = c.stamp - started_at[c.id];
          calls_done[c.id] = calls_done[c.id] + COUNT_W'(1);
          time_sum[c.id]   = time_sum[c.id] + elapsed;
          elapsed_sum      = elapsed_sum + elapsed;
          if (time_min[c.id] > elapsed) begin
            time_min[c.id] = elapsed;
          end
          if (time_max[c.id] < elapsed) begin
            time_max[c.id] = elapsed;
          end
          call_busy = 1'b0;
        end
      end
      CMD_FRAME: begin
        frame_ticks = frame_ticks + COUNT_W'(1);
      end
      default: begin
      end
    endcase
    if (entry_live[c.id]) begin
      r.count = calls_done[c.id];
      r.total = time_sum[c.id];
      r.min_t = time_min[c.id];
      r.max_t = time_max[c.id];
    end
    r.frames = frame_ticks;
    r.grand  = elapsed_sum;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [TIME_W-1:0] any_stamp();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_cmd(cmd_t cmd, int id, logic [TIME_W-1:0] stamp);
    call_cmd_t c;
    c.cmd   = cmd;
    c.id    = id[ID_W-1:0];
    c.stamp = stamp;
    pending_cmds.push_back(c);
  endtask

  // Reports one field mismatch; only the first ten are printed.
  task automatic check_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
      end
    end
  endtask

  // Driver: presents the next queued command, with random gaps in between.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_stats.push_back(apply_call_cmd(cmd_on_bus));
        accepted_cmds++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_on_bus    = pending_cmds.pop_front();
          command      <= cmd_on_bus.cmd;
          call_id      <= cmd_on_bus.id;
          timestamp_ns <= cmd_on_bus.stamp;
          in_valid     <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 39) == 0) begin
              send_calm = $urandom_range(20, 60);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      if (recv_calm > 0) begin
        recv_calm--;
        stall_len = 0;
      end else begin
        stall_len = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        if ($urandom_range(0, 59) == 0) begin
          recv_calm = $urandom_range(30, 80);
        end
      end
      if (stall_len > 0) begin
        recv_stall = stall_len - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compares every returned result with the oldest prediction.
  always @(posedge clk) begin
    call_stats_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: no transaction outstanding", results_seen);
        end
      end else begin
        want = expected_stats.pop_front();
        check_field("status", TIME_W'(want.status), TIME_W'(status));
        check_field("call_count", TIME_W'(want.count), TIME_W'(call_count));
        check_field("total_time", want.total, total_time);
        check_field("min_time", want.min_t, min_time);
        check_field("max_time", want.max_t, max_time);
        check_field("frames_seen", TIME_W'(want.frames), TIME_W'(frames_seen));
        check_field("all_calls_time", want.grand, all_calls_time);
      end
      results_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] delta;
    int                id;
    int                target;
    int                pick;

    // Directed: end on an unknown id, frame and idle commands on empty entries.
    queue_cmd(CMD_END, 0, '0);
    queue_cmd(CMD_FRAME, 5, '0);
    queue_cmd(CMD_NONE, 63, '1);
    // Largest elapsed time, then an end while idle on the same entry.
    queue_cmd(CMD_START, 0, '0);
    queue_cmd(CMD_END, 0, '1);
    queue_cmd(CMD_END, 0, '1);
    // Start while busy, then an end whose timestamp has wrapped.
    queue_cmd(CMD_START, 63, '1);
    queue_cmd(CMD_START, 63, '1);
    queue_cmd(CMD_END, 63, '0);
    // Zero elapsed time drives the minimum to zero.
    queue_cmd(CMD_START, 1, 64'd100);
    queue_cmd(CMD_END, 1, 64'd100);
    // A frame tick in the middle of a call.
    queue_cmd(CMD_START, 2, 64'd5);
    queue_cmd(CMD_FRAME, 2, 64'd6);
    queue_cmd(CMD_END, 2, 64'd1000);
    // An end on an unknown id leaves the busy flag set.
    queue_cmd(CMD_START, 3, 64'h8000_0000_0000_0000);
    queue_cmd(CMD_END, 41, 64'h8000_0000_0000_0001);
    queue_cmd(CMD_START, 4, 64'h5555_5555_5555_5555);
    queue_cmd(CMD_END, 4, 64'hAAAA_AAAA_AAAA_AAAA);
    // Ignored command on a live entry, more frames, a second call on id 2.
    queue_cmd(CMD_NONE, 1, 64'd7);
    queue_cmd(CMD_FRAME, 0, '1);
    queue_cmd(CMD_START, 2, 64'd2000);
    queue_cmd(CMD_END, 2, 64'd2003);

    // Random: mostly well-formed calls, the rest loose commands.
    target = pending_cmds.size() + RANDOM_ITEMS;
    now = any_stamp();
    while (pending_cmds.size() < target) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, ENTRY_COUNT - 1);
      if (pick < 70) begin
        queue_cmd(CMD_START, id, now);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          delta = TIME_W'($urandom_range(0, 5000));
        end else if (pick < 90) begin
          delta = {32'd0, $urandom};
        end else begin
          delta = any_stamp();
        end
        while ($urandom_range(0, 4) == 0) begin
          queue_cmd(CMD_FRAME, $urandom_range(0, ENTRY_COUNT - 1), now + delta / 2);
        end
        now = now + delta;
        queue_cmd(CMD_END, id, now);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          now = any_stamp();
        end
        pick = $urandom_range(0, 9);
        queue_cmd(pick == 0 ? CMD_NONE : cmd_t'($urandom_range(0, 2)), id,
                  $urandom_range(0, 3) == 0 ? any_stamp() : now);
      end
      now = now + TIME_W'($urandom_range(0, 200));
    end
    total_cmds = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cmds < total_cmds) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
